### design/four_register_alu_with_zero_flag_macros.svh
// Assertion macros for the four-register ALU.
`ifndef FOUR_REGISTER_ALU_WITH_ZERO_FLAG_MACROS_SVH
`define FOUR_REGISTER_ALU_WITH_ZERO_FLAG_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define FRA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge out of reset.
`define FRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/fra_pkg.sv
// Shared types, codes and constants of the four-register ALU.
package fra_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned SelW  = 3;
  localparam int unsigned StsW  = 2;
  localparam int unsigned CntW  = 5;

  typedef logic [OpW-1:0]   op_t;
  typedef logic [SelW-1:0]  sel_t;
  typedef logic [StsW-1:0]  status_t;
  typedef logic [DataW-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam op_t OP_MOV = 3'd0;
  localparam op_t OP_ADD = 3'd1;
  localparam op_t OP_SUB = 3'd2;
  localparam op_t OP_MUL = 3'd3;
  localparam op_t OP_DIV = 3'd4;
  localparam op_t OP_INC = 3'd5;
  localparam op_t OP_DEC = 3'd6;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_REG  = 2'd1;
  localparam status_t ST_DIV_ZERO = 2'd2;
  localparam status_t ST_BAD_OP   = 2'd3;

  localparam cnt_t ITER_LAST = cnt_t'(DataW - 1);

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic iter;
  } sts_t;

endpackage

### design/fra_in_if.sv
// Input channel carrying one instruction per transfer.
interface fra_in_if;
  logic                      valid;
  logic                      ready;
  fra_pkg::op_t              op;
  fra_pkg::sel_t             reg_sel;
  logic signed [fra_pkg::DataW-1:0] operand;

  modport source (output valid, output op, output reg_sel, output operand, input ready);
  modport sink   (input valid, input op, input reg_sel, input operand, output ready);
endinterface

### design/fra_out_if.sv
// Output channel carrying one result per transfer.
interface fra_out_if;
  logic                      valid;
  logic                      ready;
  fra_pkg::status_t          status;
  logic signed [fra_pkg::DataW-1:0] reg_value;
  logic                      zero_flag;
  fra_pkg::word_t            pc_value;

  modport source (output valid, output status, output reg_value, output zero_flag,
                  output pc_value, input ready);
  modport sink   (input valid, input status, input reg_value, input zero_flag,
                  input pc_value, output ready);
endinterface

### design/fra_ctrl.sv
// Controller state machine that sequences load, iteration and commit.
module fra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_ready_i,
  input  fra_pkg::sts_t   sts_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output fra_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ITER,
    S_WRITE
  } state_e;

  state_e        state_q;
  fra_pkg::cnt_t cnt_q;
  logic          out_valid_q;
  logic          commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign commit      = (state_q == S_WRITE) && (!out_valid_q || out_ready_i);

  assign cmd_o.load   = in_ready_o && in_valid_i;
  assign cmd_o.step   = (state_q == S_ITER);
  assign cmd_o.commit = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= '0;
            state_q <= sts_i.iter ? S_ITER : S_WRITE;
          end
        end
        S_ITER: begin
          cnt_q <= cnt_q + fra_pkg::cnt_t'(1);
          if (cnt_q == fra_pkg::ITER_LAST) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/fra_dpath.sv
// Datapath: register file, program counter, zero flag, ALU and shared mul/div unit.
module fra_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fra_pkg::cmd_t         cmd_i,
  output fra_pkg::sts_t         sts_o,
  input  fra_pkg::op_t          op_i,
  input  fra_pkg::sel_t         reg_sel_i,
  input  fra_pkg::word_t        operand_i,
  output fra_pkg::status_t      status_o,
  output fra_pkg::word_t        reg_value_o,
  output logic                  zero_flag_o,
  output fra_pkg::word_t        pc_value_o
);

  fra_pkg::word_t   gp_q [4];
  fra_pkg::word_t   pc_q;
  logic             zf_q;

  fra_pkg::op_t     op_q;
  fra_pkg::sel_t    sel_q;
  fra_pkg::word_t   opnd_q;
  fra_pkg::word_t   a_q;
  logic             neg_q;
  fra_pkg::word_t   wa_q;
  fra_pkg::word_t   wb_q;
  logic [fra_pkg::DataW:0] acc_q;

  fra_pkg::status_t status_q;
  fra_pkg::word_t   rv_q;
  logic             zfo_q;
  fra_pkg::word_t   pco_q;

  fra_pkg::word_t   in_a;
  fra_pkg::word_t   a_abs;
  fra_pkg::word_t   b_abs;
  logic [fra_pkg::DataW:0] rem_sh;
  logic [fra_pkg::DataW:0] diff;
  fra_pkg::word_t   res;
  fra_pkg::status_t st;
  logic             zf_upd;
  logic             sel_bad;

  assign in_a  = gp_q[reg_sel_i[1:0]];
  assign a_abs = in_a[fra_pkg::DataW-1] ? (fra_pkg::word_t'(0) - in_a) : in_a;
  assign b_abs = operand_i[fra_pkg::DataW-1] ? (fra_pkg::word_t'(0) - operand_i) : operand_i;

  assign sts_o.iter = (op_i == fra_pkg::OP_MUL) ||
                      ((op_i == fra_pkg::OP_DIV) && (operand_i != '0));

  assign rem_sh = {acc_q[fra_pkg::DataW-1:0], wa_q[fra_pkg::DataW-1]};
  assign diff   = rem_sh - {1'b0, wb_q};

  assign sel_bad = sel_q[2];

  always_comb begin
    res    = a_q;
    st     = fra_pkg::ST_OK;
    zf_upd = 1'b0;
    case (op_q)
      fra_pkg::OP_MOV: begin
        res    = opnd_q;
        zf_upd = 1'b1;
      end
      fra_pkg::OP_ADD: begin
        res    = a_q + opnd_q;
        zf_upd = 1'b1;
      end
      fra_pkg::OP_SUB: begin
        res    = a_q - opnd_q;
        zf_upd = 1'b1;
      end
      fra_pkg::OP_MUL: begin
        res = acc_q[fra_pkg::DataW-1:0];
      end
      fra_pkg::OP_DIV: begin
        if (opnd_q == '0) begin
          st = fra_pkg::ST_DIV_ZERO;
        end else begin
          res = neg_q ? (fra_pkg::word_t'(0) - wa_q) : wa_q;
        end
      end
      fra_pkg::OP_INC: begin
        res = a_q + fra_pkg::word_t'(1);
      end
      fra_pkg::OP_DEC: begin
        res = a_q - fra_pkg::word_t'(1);
      end
      default: begin
        st = fra_pkg::ST_BAD_OP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q[0] <= '0;
      gp_q[1] <= '0;
      gp_q[2] <= '0;
      gp_q[3] <= '0;
      pc_q    <= '0;
      zf_q    <= 1'b0;
    end else if (cmd_i.commit && !sel_bad) begin
      gp_q[sel_q[1:0]] <= res;
      pc_q             <= pc_q + fra_pkg::word_t'(1);
      if (zf_upd) begin
        zf_q <= (res == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      sel_q  <= reg_sel_i;
      opnd_q <= operand_i;
      a_q    <= in_a;
      neg_q  <= in_a[fra_pkg::DataW-1] ^ operand_i[fra_pkg::DataW-1];
      acc_q  <= '0;
      if (op_i == fra_pkg::OP_DIV) begin
        wa_q <= a_abs;
        wb_q <= b_abs;
      end else begin
        wa_q <= operand_i;
        wb_q <= in_a;
      end
    end else if (cmd_i.step) begin
      if (op_q == fra_pkg::OP_DIV) begin
        if (!diff[fra_pkg::DataW]) begin
          acc_q <= diff;
        end else begin
          acc_q <= rem_sh;
        end
        wa_q <= {wa_q[fra_pkg::DataW-2:0], ~diff[fra_pkg::DataW]};
      end else begin
        if (wa_q[0]) begin
          acc_q <= {1'b0, acc_q[fra_pkg::DataW-1:0] + wb_q};
        end
        wa_q <= {1'b0, wa_q[fra_pkg::DataW-1:1]};
        wb_q <= {wb_q[fra_pkg::DataW-2:0], 1'b0};
      end
    end
    if (cmd_i.commit) begin
      if (sel_bad) begin
        status_q <= fra_pkg::ST_BAD_REG;
        rv_q     <= '0;
        zfo_q    <= zf_q;
        pco_q    <= pc_q;
      end else begin
        status_q <= st;
        rv_q     <= res;
        zfo_q    <= zf_upd ? (res == '0) : zf_q;
        pco_q    <= pc_q + fra_pkg::word_t'(1);
      end
    end
  end

  assign status_o    = status_q;
  assign reg_value_o = rv_q;
  assign zero_flag_o = zfo_q;
  assign pc_value_o  = pco_q;

endmodule

### design/four_register_alu_with_zero_flag.sv
// Four-register ALU with zero flag: one instruction per input transfer, one result each.
// MOV, ADD, SUB, INC, DEC, DIV by zero and unknown ops go straight to the write state;
// MUL and nonzero DIV first take 32 steps of the shared shift-add/restoring unit,
// bad register or not. A new instruction is taken the cycle after the previous one commits.
// Reset clears Ax..Dx, the zero flag, the program counter and the output valid at once.
module four_register_alu_with_zero_flag (
  input  logic      clk_i,
  input  logic      rst_ni,
  fra_in_if.sink    in_i,
  fra_out_if.source out_o
);

  `include "four_register_alu_with_zero_flag_macros.svh"

  fra_pkg::cmd_t cmd;
  fra_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;
  fra_pkg::word_t rv;

  fra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  fra_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (in_i.op),
    .reg_sel_i   (in_i.reg_sel),
    .operand_i   (fra_pkg::word_t'(in_i.operand)),
    .status_o    (out_o.status),
    .reg_value_o (rv),
    .zero_flag_o (out_o.zero_flag),
    .pc_value_o  (out_o.pc_value)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.reg_value = $signed(rv);

  `FRA_ASSERT_NEXT(a_busy_after_transfer, in_i.valid && in_i.ready, !in_i.ready)
  `FRA_ASSERT_NEXT(a_commit_shows_valid, cmd.commit, out_o.valid)
  `FRA_ASSERT_IMPL(a_bad_reg_zero_value,
                   out_o.valid && (out_o.status == fra_pkg::ST_BAD_REG), out_o.reg_value == 0)

endmodule
